// ===== rtl/core/snrg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package snrg_pkg;

	localparam logic [16:0] ONE_Q16 = 17'h10000;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_SNR_LOW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SNR_HIGH = 2'd1;

	// 32 quotient bits, then 16 root digits, two of each per stage
	localparam int DIV_PER_STAGE  = 2;
	localparam int DIV_STAGES     = 32 / DIV_PER_STAGE;
	localparam int SQRT_PER_STAGE = 2;
	localparam int SQRT_STAGES    = 16 / SQRT_PER_STAGE;

	typedef struct packed {
		logic        between;
		logic [16:0] fixed_gain;
		logic        flag;
	} snrg_side_t;

	typedef struct packed {
		logic [23:0] rem;
		logic [23:0] den;
		logic [31:0] quo;
		snrg_side_t  side;
	} snrg_div_t;

	typedef struct packed {
		logic [17:0] rem;
		logic [15:0] root;
		logic [31:0] rad;
		snrg_side_t  side;
	} snrg_sqrt_t;

	typedef struct packed {
		logic [16:0] gain;
		logic        flag;
	} snrg_res_t;

	// restoring division; remainder stays below the divisor when it starts below it
	function automatic snrg_div_t snrg_div_step(input snrg_div_t cur);
		snrg_div_t   nxt;
		logic [24:0] t;
		nxt = cur;
		for (int i = 0; i < DIV_PER_STAGE; i++) begin
			t = {nxt.rem, 1'b0};
			if (t >= {1'b0, nxt.den}) begin
				nxt.rem = 24'(t - {1'b0, nxt.den});
				nxt.quo = {nxt.quo[30:0], 1'b1};
			end else begin
				nxt.rem = t[23:0];
				nxt.quo = {nxt.quo[30:0], 1'b0};
			end
		end
		return nxt;
	endfunction

	// digit-by-digit square root, one bit pair of the radicand per step
	function automatic snrg_sqrt_t snrg_sqrt_step(input snrg_sqrt_t cur);
		snrg_sqrt_t  nxt;
		logic [19:0] tmp;
		logic [19:0] trial;
		nxt = cur;
		for (int i = 0; i < SQRT_PER_STAGE; i++) begin
			tmp   = {nxt.rem, nxt.rad[31:30]};
			trial = {2'b00, nxt.root, 2'b01};
			if (tmp >= trial) begin
				nxt.rem  = 18'(tmp - trial);
				nxt.root = {nxt.root[14:0], 1'b1};
			end else begin
				nxt.rem  = tmp[17:0];
				nxt.root = {nxt.root[14:0], 1'b0};
			end
			nxt.rad = {nxt.rad[29:0], 2'b00};
		end
		return nxt;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/snrg_root_pipe.sv =====
`timescale 1ns / 1ps
`default_nettype none

module snrg_root_pipe (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   en,
	input  wire logic                   src_valid,
	input  snrg_pkg::snrg_div_t         src,
	output logic                        dst_valid,
	output logic [15:0]                 dst_root,
	output snrg_pkg::snrg_side_t        dst_side
);
	import snrg_pkg::*;

	snrg_div_t  div_s   [1:DIV_STAGES];
	logic       div_v_s [1:DIV_STAGES];
	snrg_sqrt_t sq_s    [1:SQRT_STAGES];
	logic       sq_v_s  [1:SQRT_STAGES];

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
		snrg_div_t prev;
		logic      prev_v;
		snrg_div_t step;

		if (k == 0) begin : g_src
			assign prev   = src;
			assign prev_v = src_valid;
		end else begin : g_chain
			assign prev   = div_s[k];
			assign prev_v = div_v_s[k];
		end

		always_comb step = snrg_div_step(prev);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_v_s[k+1] <= 1'b0;
			end else if (en) begin
				div_v_s[k+1] <= prev_v;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				div_s[k+1] <= step;
			end
		end
	end

	for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sqrt
		snrg_sqrt_t prev;
		logic       prev_v;
		snrg_sqrt_t step;

		if (k == 0) begin : g_src
			assign prev.rem  = '0;
			assign prev.root = '0;
			assign prev.rad  = div_s[DIV_STAGES].quo;
			assign prev.side = div_s[DIV_STAGES].side;
			assign prev_v    = div_v_s[DIV_STAGES];
		end else begin : g_chain
			assign prev   = sq_s[k];
			assign prev_v = sq_v_s[k];
		end

		always_comb step = snrg_sqrt_step(prev);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v_s[k+1] <= 1'b0;
			end else if (en) begin
				sq_v_s[k+1] <= prev_v;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_s[k+1] <= step;
			end
		end
	end

	assign dst_valid = sq_v_s[SQRT_STAGES];
	assign dst_root  = sq_s[SQRT_STAGES].root;
	assign dst_side  = sq_s[SQRT_STAGES].side;

endmodule

`default_nettype wire

// ===== rtl/core/snr_gated_regularization_gain.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Regularization gain per Fourier-domain pixel.
// Input channel (in_valid / in_stall): one pixel, aperture_value (Q1.16) and
// snr_value (Q16.8), taken on any edge with in_valid high and in_stall low.
// Output channel (out_valid / out_stall): gain_value (Q1.16) and
// stabilize_flag, one result per pixel, in order.
// Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): index 0 is the
// low SNR threshold, index 1 the high one; other indexes are dropped.
// cfg_ready is always high. Write only while no pixel is in flight.
// Throughput: one pixel per cycle while in_stall is low; the 32-bit quotient
// (16 stages, 2 bits each) and the 16-bit root (8 stages, 2 bits each) are
// fully pipelined.
// Stall: a 2-entry output buffer absorbs results; once it is full the whole
// pipeline freezes and in_stall goes high, with no item lost or repeated.
// in_stall depends only on registered state.
// Reset clears the thresholds to zero and empties the pipeline and buffer.

module snr_gated_regularization_gain (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [16:0] aperture_value,
	input  wire logic [23:0] snr_value,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [16:0]      gain_value,
	output logic             stabilize_flag,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [23:0] cfg_data
);
	import snrg_pkg::*;

	logic [23:0] lo_q;
	logic [23:0] hi_q;

	logic        en;
	logic        accept;

	logic        is_one;
	logic        ge_hi;
	logic        ge_lo;
	logic [16:0] abs_diff;
	snrg_div_t   front;

	logic        v_s1;
	snrg_div_t   data_s1;

	logic        last_v;
	logic [15:0] last_root;
	snrg_side_t  last_side;
	snrg_res_t   push_data;
	logic        push;
	logic        pop;

	logic [1:0]  cnt_q;
	snrg_res_t   slot0_q;
	snrg_res_t   slot1_q;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_q <= '0;
			hi_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SNR_LOW:  lo_q <= cfg_data;
				REG_SNR_HIGH: hi_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// pipeline runs while the output buffer has room
	assign en       = (cnt_q != 2'd2);
	assign in_stall = !en;
	assign accept   = in_valid && en;

	// stage 1: classify the pixel, set up the divide
	always_comb begin
		is_one   = (aperture_value == ONE_Q16);
		ge_hi    = (snr_value >= hi_q);
		ge_lo    = (snr_value >= lo_q);
		abs_diff = (aperture_value < ONE_Q16) ? 17'(ONE_Q16 - aperture_value)
		                                      : 17'(aperture_value - ONE_Q16);
		front.rem             = 24'(snr_value - lo_q);
		front.den             = 24'(hi_q - lo_q);
		front.quo             = '0;
		front.side.between    = is_one && !ge_hi && ge_lo;
		front.side.fixed_gain = is_one ? (ge_hi ? ONE_Q16 : 17'd0) : abs_diff;
		front.side.flag       = !is_one && !ge_lo;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s1 <= front;
		end
	end

	snrg_root_pipe u_root_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.src_valid (v_s1),
		.src       (data_s1),
		.dst_valid (last_v),
		.dst_root  (last_root),
		.dst_side  (last_side)
	);

	assign push_data.gain = last_side.between ? {1'b0, last_root} : last_side.fixed_gain;
	assign push_data.flag = last_side.flag;

	// output buffer, two entries, slot0 is the head
	assign push = en && last_v;
	assign pop  = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= 2'(cnt_q + {1'b0, push} - {1'b0, pop});
		end
	end

	always_ff @(posedge clk) begin
		if (pop && cnt_q == 2'd2) begin
			slot0_q <= slot1_q;
		end else if (push && (cnt_q == 2'd0 || (cnt_q == 2'd1 && pop))) begin
			slot0_q <= push_data;
		end
		if (push && cnt_q == 2'd1 && !pop) begin
			slot1_q <= push_data;
		end
	end

	assign out_valid      = (cnt_q != 2'd0);
	assign gain_value     = slot0_q.gain;
	assign stabilize_flag = slot0_q.flag;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("output buffer count out of range");

	a_accept_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> v_s1)
		else $error("accepted item missing from first stage");

	a_gain_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && gain_value[16]) |-> (gain_value[15:0] == 16'd0))
		else $error("gain above one");

	a_full_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && cnt_q == 2'd2) |=> out_valid)
		else $error("second buffered result lost");

endmodule

`default_nettype wire

// ===== dv/tb_snr_gated_regularization_gain.sv =====
`timescale 1ns / 1ps

module tb_snr_gated_regularization_gain;

	import snrg_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASES = 12;
	localparam int PHASE_ITEMS = 68;

	class gain_checker;
		logic [23:0] snr_lo;
		logic [23:0] snr_hi;
		snrg_res_t   expected_gains[$];
		int          errors;

		function new();
			snr_lo = '0;
			snr_hi = '0;
			errors = 0;
		endfunction

		function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] data);
			case (idx)
				REG_SNR_LOW: begin
					snr_lo = data;
				end
				REG_SNR_HIGH: begin
					snr_hi = data;
				end
				default: begin
				end
			endcase
		endfunction

		function void note_pixel(input logic [16:0] ap, input logic [23:0] snr);
			snrg_res_t   want;
			logic [63:0] ratio;
			logic [63:0] sq;
			logic [15:0] root;
			logic [15:0] cand;
			want.gain = '0;
			want.flag = 1'b0;
			if (ap == ONE_Q16) begin
				if (snr >= snr_hi) begin
					want.gain = ONE_Q16;
				end else if (snr >= snr_lo) begin
					// Q0.32 ratio of the position between thresholds, always below one
					ratio = {8'd0, 24'(snr - snr_lo), 32'd0} / {40'd0, 24'(snr_hi - snr_lo)};
					root = '0;
					for (int b = 15; b >= 0; b--) begin
						cand = root | (16'd1 << b);
						sq = 64'(cand) * 64'(cand);
						if (sq <= ratio)
							root = cand;
					end
					want.gain = {1'b0, root};
				end
			end else begin
				want.gain = (ap < ONE_Q16) ? 17'(ONE_Q16 - ap) : 17'(ap - ONE_Q16);
				want.flag = (snr < snr_lo);
			end
			expected_gains.push_back(want);
		endfunction

		function void check_result(input logic [16:0] gain, input logic flag);
			snrg_res_t want;
			if (expected_gains.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, gain_value %0d stabilize_flag %0b",
					$time, gain, flag);
			end else begin
				want = expected_gains.pop_front();
				if (gain !== want.gain) begin
					errors++;
					$display("%0t: gain_value mismatch, expected %0d, got %0d",
						$time, want.gain, gain);
				end
				if (flag !== want.flag) begin
					errors++;
					$display("%0t: stabilize_flag mismatch, expected %0b, got %0b",
						$time, want.flag, flag);
				end
			end
		endfunction

		function int pending();
			return expected_gains.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [16:0] aperture_value;
	logic [23:0] snr_value;
	logic        out_valid;
	logic        out_stall;
	logic [16:0] gain_value;
	logic        stabilize_flag;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [23:0] cfg_data;

	gain_checker sb;
	int          next_gap;
	bit          tx_calm;
	bit          rx_calm;
	bit          hold_req;
	int unsigned cycle_count;

	snr_gated_regularization_gain i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.aperture_value (aperture_value),
		.snr_value      (snr_value),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.gain_value     (gain_value),
		.stabilize_flag (stabilize_flag),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 9);
		if (tx_calm || r < 6)
			return 0;
		else if (r < 9)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	function automatic logic [16:0] rand_aperture();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return ONE_Q16;
			4: return 17'($urandom_range(0, 65535));
			5: return 17'($urandom_range(65537, 131071));
			6: return $urandom_range(0, 1) ? 17'(ONE_Q16 + 1) : 17'(ONE_Q16 - 1);
			default: return 17'($urandom);
		endcase
	endfunction

	function automatic logic [23:0] rand_snr(input logic [23:0] lo, input logic [23:0] hi);
		case ($urandom_range(0, 7))
			0: return 24'(lo - 24'd1);
			1: return lo;
			2: return 24'(hi - 24'd1);
			3: return hi;
			4, 5: return (hi > lo) ? 24'(lo + ($urandom % (hi - lo))) : 24'($urandom);
			6: return $urandom_range(0, 1) ? 24'hFFFFFF : 24'h0;
			default: return 24'($urandom);
		endcase
	endfunction

	// valid stays high between back-to-back items; it drops only ahead of a gap
	task automatic send_pixel(input logic [16:0] ap, input logic [23:0] snr);
		if (next_gap > 0)
			repeat (next_gap) @(posedge clk);
		in_valid <= 1'b1;
		aperture_value <= ap;
		snr_value <= snr;
		do @(posedge clk); while (in_stall);
		sb.note_pixel(ap, snr);
		next_gap = pick_gap();
		if (next_gap > 0)
			in_valid <= 1'b0;
	endtask

	task automatic end_burst();
		if (next_gap == 0) begin
			in_valid <= 1'b0;
			next_gap = 1;
		end
	endtask

	task automatic wait_drain();
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, data);
	endtask

	task automatic set_thresholds(input logic [23:0] lo, input logic [23:0] hi);
		write_cfg(REG_SNR_LOW, lo);
		write_cfg(REG_SNR_HIGH, hi);
		// unused indexes must leave the thresholds alone
		if ($urandom_range(0, 1))
			write_cfg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, 24'($urandom));
		cfg_valid <= 1'b0;
	endtask

	// result side: random stalls, calm stretches, and one long hold on request
	initial begin
		int run_left;
		int hold_left;
		run_left = 0;
		hold_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall)
				sb.check_result(gain_value, stabilize_flag);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (run_left > 0) begin
				run_left--;
			end else if (rx_calm || $urandom_range(0, 2) != 0) begin
				out_stall <= 1'b0;
				run_left = $urandom_range(0, 8);
			end else begin
				out_stall <= 1'b1;
				run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50)
					: $urandom_range(0, 3);
			end
		end
	end

	initial begin
		logic [16:0] ap;
		logic [23:0] snr;
		logic [23:0] lo;
		logic [23:0] hi;
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		aperture_value = '0;
		snr_value = '0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		next_gap = 0;
		tx_calm = 1'b0;
		rx_calm = 1'b0;
		hold_req = 1'b0;
		cycle_count = 0;
		sb = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// thresholds straight out of reset
		for (int k = 0; k < 15; k++)
			send_pixel(rand_aperture(), 24'($urandom));
		end_burst();
		wait_drain();

		set_thresholds(24'h000100, 24'h010000);
		for (int k = 0; k < 18; k++) begin
			case (k)
				0: begin ap = ONE_Q16; snr = 24'h000000; end
				1: begin ap = ONE_Q16; snr = 24'h0000FF; end
				2: begin ap = ONE_Q16; snr = 24'h000100; end
				3: begin ap = ONE_Q16; snr = 24'h000101; end
				4: begin ap = ONE_Q16; snr = 24'h008080; end
				5: begin ap = ONE_Q16; snr = 24'h00FFFF; end
				6: begin ap = ONE_Q16; snr = 24'h010000; end
				7: begin ap = ONE_Q16; snr = 24'hFFFFFF; end
				8: begin ap = 17'd0; snr = 24'h000000; end
				9: begin ap = 17'd0; snr = 24'hFFFFFF; end
				10: begin ap = 17'd1; snr = 24'h0000FF; end
				11: begin ap = 17'd65535; snr = 24'h000100; end
				12: begin ap = 17'd65537; snr = 24'h0000FF; end
				13: begin ap = 17'd131071; snr = 24'h000000; end
				14: begin ap = 17'd131071; snr = 24'hFFFFFF; end
				15: begin ap = 17'h15555; snr = 24'hAAAAAA; end
				16: begin ap = 17'h0AAAA; snr = 24'h555555; end
				default: begin ap = 17'h10000; snr = 24'h000080; end
			endcase
			send_pixel(ap, snr);
		end
		end_burst();
		wait_drain();

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin lo = 24'h000000; hi = 24'hFFFFFF; end
				1: begin lo = 24'($urandom); hi = lo; end
				2: begin
					lo = 24'($urandom_range(1, 24'hFFFFFF));
					hi = 24'($urandom_range(0, lo - 1));
				end
				3: begin lo = 24'h001000; hi = 24'h00F000; end
				4: begin lo = 24'hFFFFFF; hi = 24'hFFFFFF; end
				5: begin lo = 24'h000000; hi = 24'h000001; end
				6: begin lo = 24'hFFFFFE; hi = 24'hFFFFFF; end
				7: begin lo = 24'h000000; hi = 24'h000000; end
				default: begin
					lo = 24'($urandom_range(0, 24'hFFF000));
					hi = $urandom_range(0, 1) ? 24'(lo + $urandom_range(1, 4095))
						: 24'($urandom_range(lo, 24'hFFFFFF));
				end
			endcase
			set_thresholds(lo, hi);
			tx_calm = (p == 3) || ($urandom_range(0, 4) == 0);
			rx_calm = ($urandom_range(0, 4) == 0);
			// long output hold while items keep coming: pipeline fills, input stalls
			if (p == 3)
				hold_req = 1'b1;
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if (p == 6 && k == PHASE_ITEMS / 2) begin
					end_burst();
					wait_drain();
				end
				send_pixel(rand_aperture(), rand_snr(lo, hi));
			end
			end_burst();
			wait_drain();
		end

		repeat (40) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
